// ===== design/obav_pkg.sv =====
`default_nettype none

package obav_pkg;

   localparam int unsigned BEARING_W = 9;
   localparam int unsigned DIST_W    = 9;
   localparam int unsigned DEV_W     = 8;

   localparam logic [BEARING_W-1:0] DEG_FULL = BEARING_W'(360);
   localparam logic [BEARING_W-1:0] DEG_HALF = BEARING_W'(180);

   // Heading arithmetic results handed from the heading unit to the mode machine.
   typedef struct packed {
      logic                 is_right;    // bearing lies clockwise of the destination
      logic [BEARING_W-1:0] bearing_mod; // current bearing reduced into 0..359
      logic [BEARING_W-1:0] new_dest;    // bearing turned toward the freer side
   } hdg_result_type;

endpackage

`default_nettype wire

// ===== design/obstacle_avoid_nav_fsm_core.sv =====
`default_nettype none

// Navigation mode machine for a small obstacle-avoiding robot. Each input item is a
// tick carrying compass bearing and four ultrasonic distances, or a start or stop
// event (kind in req_tuser); every item yields exactly one result item with the
// motor, servo and LED commands, the new mode and the stored target bearing. The
// block takes one item per clock cycle: the whole mode decision is combinational
// logic into the result register, and a new item is accepted whenever that
// register is empty or being drained in the same cycle. Timed phases of the
// avoidance sequence count input ticks, not clock cycles. Configuration writes on
// the csr_ channel are always accepted and should be issued while no item is in
// flight.
module obstacle_avoid_nav_fsm_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // bearing[8:0], dist_ahead[17:9], dist_left_diag[26:18], dist_right_diag[35:27],
   // dist_behind[44:36], zero[47:45]
   input  wire logic [47:0] req_tdata,
   // action[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // motor_cmd[3:0], servo_cmd[5:4], led_cmd[7:6], mode_now[11:8],
   // target_heading[20:12], zero[23:21]
   output logic [23:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   import obav_pkg::*;

   typedef enum logic [3:0] {
      MODE_IDLE       = 4'd0,
      MODE_STARTING   = 4'd1,
      MODE_EXPLORING  = 4'd2,
      MODE_CORRECT    = 4'd3,
      MODE_TURNING    = 4'd4,
      MODE_TURN_PAUSE = 4'd5,
      MODE_AVOID      = 4'd6,
      MODE_AV_PAUSE   = 4'd7,
      MODE_AV_REVERSE = 4'd8,
      MODE_AV_SETTLE  = 4'd9
   } mode_type;

   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;

   localparam logic [3:0] MOTOR_NONE    = 4'd0;
   localparam logic [3:0] MOTOR_FWD     = 4'd1;
   localparam logic [3:0] MOTOR_BACK    = 4'd2;
   localparam logic [3:0] MOTOR_IDLE    = 4'd3;
   localparam logic [3:0] MOTOR_LEFT    = 4'd4;
   localparam logic [3:0] MOTOR_RIGHT   = 4'd5;
   localparam logic [3:0] MOTOR_FWD_L   = 4'd6;
   localparam logic [3:0] MOTOR_FWD_R   = 4'd7;
   localparam logic [3:0] MOTOR_NORMAL  = 4'd8;
   localparam logic [3:0] MOTOR_REDUCED = 4'd9;

   localparam logic [1:0] SERVO_NONE   = 2'd0;
   localparam logic [1:0] SERVO_SWEEP  = 2'd1;
   localparam logic [1:0] SERVO_CENTER = 2'd2;

   localparam logic [1:0] LED_NONE = 2'd0;
   localparam logic [1:0] LED_ON   = 2'd1;
   localparam logic [1:0] LED_OFF  = 2'd2;

   localparam logic [2:0] REG_FRONT_STOP   = 3'd0;
   localparam logic [2:0] REG_FRONT_DANGER = 3'd1;
   localparam logic [2:0] REG_REAR_CLEAR   = 3'd2;
   localparam logic [2:0] REG_PAUSE        = 3'd3;
   localparam logic [2:0] REG_REVERSE      = 3'd4;
   localparam logic [2:0] REG_SETTLE       = 3'd5;
   localparam logic [2:0] REG_DEVIATION    = 3'd6;

   logic [DIST_W-1:0]    front_stop_ff, front_danger_ff, rear_clear_ff;
   logic [15:0]          pause_ff, reverse_ff, settle_ff;
   logic [DEV_W-1:0]     deviation_ff;

   mode_type             mode_ff, mode_in;
   logic [BEARING_W-1:0] dest_ff, dest_in;
   logic [15:0]          wait_ff, wait_in;
   logic                 rsp_valid_ff;
   logic [23:0]          rsp_data_ff;

   logic [3:0]           motor;
   logic [1:0]           servo, led;

   logic [1:0]           action;
   logic [BEARING_W-1:0] bearing;
   logic [DIST_W-1:0]    front, left, right, rear;
   logic                 accept;
   hdg_result_type       hdg;

   assign action  = req_tuser;
   assign bearing = req_tdata[8:0];
   assign front   = req_tdata[17:9];
   assign left    = req_tdata[26:18];
   assign right   = req_tdata[35:27];
   assign rear    = req_tdata[44:36];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   obav_heading u_heading (
      .bearing    (bearing),
      .dest       (dest_ff),
      .dist_left  (left),
      .dist_right (right),
      .deviation  (deviation_ff),
      .result     (hdg)
   );

   always_comb begin
      motor   = MOTOR_NONE;
      servo   = SERVO_NONE;
      led     = LED_NONE;
      mode_in = mode_ff;
      dest_in = dest_ff;
      wait_in = wait_ff;
      if (action == ACT_START) begin
         mode_in = MODE_STARTING;
         wait_in = '0;
      end else if (action != ACT_TICK) begin
         motor   = MOTOR_IDLE;
         servo   = SERVO_CENTER;
         led     = LED_OFF;
         mode_in = MODE_IDLE;
         wait_in = '0;
      end else begin
         case (mode_ff)
            MODE_CORRECT: begin
               motor   = hdg.is_right ? MOTOR_FWD_L : MOTOR_FWD_R;
               mode_in = MODE_EXPLORING;
            end
            MODE_EXPLORING: begin
               if (bearing != dest_ff) begin
                  mode_in = MODE_CORRECT;
               end
               // A blocked front overrides a pending heading correction.
               if (front < front_stop_ff) begin
                  mode_in = MODE_AVOID;
               end else if (front < front_danger_ff) begin
                  motor = MOTOR_REDUCED;
               end else begin
                  motor = MOTOR_NORMAL;
               end
            end
            MODE_STARTING: begin
               servo = SERVO_SWEEP;
               led   = LED_ON;
               if (left != '0 && right != '0 && front != '0) begin
                  dest_in = hdg.bearing_mod;
                  motor   = MOTOR_FWD;
                  mode_in = MODE_EXPLORING;
               end
            end
            MODE_TURNING: begin
               if (bearing != dest_ff) begin
                  motor = (bearing < dest_ff) ? MOTOR_RIGHT : MOTOR_LEFT;
               end else begin
                  motor   = MOTOR_IDLE;
                  wait_in = pause_ff;
                  mode_in = MODE_TURN_PAUSE;
               end
            end
            MODE_AVOID: begin
               motor   = MOTOR_IDLE;
               servo   = SERVO_CENTER;
               led     = LED_OFF;
               wait_in = pause_ff;
               mode_in = MODE_AV_PAUSE;
            end
            MODE_TURN_PAUSE, MODE_AV_PAUSE, MODE_AV_REVERSE, MODE_AV_SETTLE: begin
               if (wait_ff != '0) begin
                  wait_in = wait_ff - 16'd1;
               end else if (mode_ff == MODE_TURN_PAUSE) begin
                  motor   = MOTOR_FWD;
                  servo   = SERVO_SWEEP;
                  led     = LED_ON;
                  mode_in = MODE_EXPLORING;
               end else if (mode_ff == MODE_AV_PAUSE && rear > rear_clear_ff) begin
                  motor   = MOTOR_BACK;
                  servo   = SERVO_CENTER;
                  led     = LED_OFF;
                  wait_in = reverse_ff;
                  mode_in = MODE_AV_REVERSE;
               end else if (mode_ff == MODE_AV_SETTLE) begin
                  dest_in = hdg.new_dest;
                  mode_in = MODE_TURNING;
               end else begin
                  // Settle phase: motor idle while the sensors sweep.
                  motor   = MOTOR_IDLE;
                  servo   = SERVO_SWEEP;
                  led     = LED_ON;
                  wait_in = settle_ff;
                  mode_in = MODE_AV_SETTLE;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_stop_ff   <= DIST_W'(20);
         front_danger_ff <= DIST_W'(40);
         rear_clear_ff   <= DIST_W'(15);
         pause_ff        <= 16'd2000;
         reverse_ff      <= 16'd1500;
         settle_ff       <= 16'd1000;
         deviation_ff    <= DEV_W'(40);
         mode_ff         <= MODE_IDLE;
         dest_ff         <= '0;
         wait_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_FRONT_STOP:   front_stop_ff   <= csr_data[DIST_W-1:0];
               REG_FRONT_DANGER: front_danger_ff <= csr_data[DIST_W-1:0];
               REG_REAR_CLEAR:   rear_clear_ff   <= csr_data[DIST_W-1:0];
               REG_PAUSE:        pause_ff        <= csr_data;
               REG_REVERSE:      reverse_ff      <= csr_data;
               REG_SETTLE:       settle_ff       <= csr_data;
               REG_DEVIATION:    deviation_ff    <= csr_data[DEV_W-1:0];
               default: begin
               end
            endcase
         end
         if (accept) begin
            mode_ff      <= mode_in;
            dest_ff      <= dest_in;
            wait_ff      <= wait_in;
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= {3'b000, dest_in, mode_in, led, servo, motor};
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/obav_heading.sv =====
`default_nettype none

module obav_heading (
   input  wire logic [obav_pkg::BEARING_W-1:0] bearing,
   input  wire logic [obav_pkg::BEARING_W-1:0] dest,
   input  wire logic [obav_pkg::DIST_W-1:0]    dist_left,
   input  wire logic [obav_pkg::DIST_W-1:0]    dist_right,
   input  wire logic [obav_pkg::DEV_W-1:0]     deviation,
   output obav_pkg::hdg_result_type            result
);
   import obav_pkg::*;

   logic signed [BEARING_W+2:0] diff;
   logic                        is_right;
   logic [BEARING_W-1:0]        bearing_mod;
   logic [BEARING_W-1:0]        new_dest;
   logic [BEARING_W:0]          sum_left;
   logic [BEARING_W+1:0]        sum_right;
   logic [BEARING_W-1:0]        right_mod;
   logic [BEARING_W-1:0]        left_mod;

   // Signed difference folded by one step of a full turn.
   always_comb begin
      diff = $signed({3'b000, bearing}) - $signed({3'b000, dest});
      if (diff > $signed({3'b000, DEG_HALF})) begin
         diff = diff - $signed({3'b000, DEG_FULL});
      end else if (diff < -$signed({3'b000, DEG_HALF})) begin
         diff = diff + $signed({3'b000, DEG_FULL});
      end
      is_right = (diff > 0);
   end

   assign bearing_mod = (bearing >= DEG_FULL) ? (bearing - DEG_FULL) : bearing;

   // Clockwise target: at most 766, so up to two full turns come off.
   always_comb begin
      sum_left = {1'b0, bearing} + {{(BEARING_W+1-DEV_W){1'b0}}, deviation};
      if (sum_left >= {DEG_FULL, 1'b0}) begin
         right_mod = BEARING_W'(sum_left - {DEG_FULL, 1'b0});
      end else if (sum_left >= {1'b0, DEG_FULL}) begin
         right_mod = BEARING_W'(sum_left - {1'b0, DEG_FULL});
      end else begin
         right_mod = BEARING_W'(sum_left);
      end
   end

   // Counterclockwise target: bearing plus two turns minus deviation, 465..1231.
   always_comb begin
      sum_right = {2'b00, bearing} + {DEG_FULL, 2'b00} - {1'b0, DEG_FULL, 1'b0}
                  - {{(BEARING_W+2-DEV_W){1'b0}}, deviation};
      if (sum_right >= ({1'b0, DEG_FULL, 1'b0} + {2'b00, DEG_FULL})) begin
         left_mod = BEARING_W'(sum_right - {1'b0, DEG_FULL, 1'b0} - {2'b00, DEG_FULL});
      end else if (sum_right >= {1'b0, DEG_FULL, 1'b0}) begin
         left_mod = BEARING_W'(sum_right - {1'b0, DEG_FULL, 1'b0});
      end else if (sum_right >= {2'b00, DEG_FULL}) begin
         left_mod = BEARING_W'(sum_right - {2'b00, DEG_FULL});
      end else begin
         left_mod = BEARING_W'(sum_right);
      end
   end

   // Equal diagonals pick the left turn.
   assign new_dest = (dist_left < dist_right) ? right_mod : left_mod;

   assign result = {is_right, bearing_mod, new_dest};

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import obav_pkg::*;

   localparam int CLK_HALF        = 6;
   localparam int RESET_CYCLES    = 8;
   localparam int PHASES          = 12;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int SHOW_LIMIT      = 10;

   typedef enum logic [3:0] {
      MODE_IDLE, MODE_STARTING, MODE_EXPLORING, MODE_CORRECT, MODE_TURNING,
      MODE_TURN_PAUSE, MODE_AVOID, MODE_AV_PAUSE, MODE_AV_REVERSE, MODE_AV_SETTLE
   } nav_mode_e;

   typedef enum logic [3:0] {
      MOT_NONE, MOT_FWD, MOT_BACK, MOT_IDLE, MOT_LEFT, MOT_RIGHT,
      MOT_FWD_LEFT, MOT_FWD_RIGHT, MOT_NORMAL, MOT_REDUCED
   } motor_e;

   typedef enum logic [1:0] {SERVO_NONE, SERVO_SWEEP, SERVO_CENTER} servo_e;
   typedef enum logic [1:0] {LED_NONE, LED_ON, LED_OFF} led_e;
   typedef enum logic [1:0] {ACT_TICK, ACT_START, ACT_STOP, ACT_STOP_ALT} action_e;

   typedef enum logic [2:0] {
      CSR_FRONT_STOP, CSR_FRONT_DANGER, CSR_REAR_CLEAR, CSR_PAUSE,
      CSR_REVERSE, CSR_SETTLE, CSR_TURN_DEV, CSR_UNUSED
   } csr_idx_e;

   typedef struct packed {
      logic [1:0]         action;
      logic [BEARING_W-1:0] bearing;
      logic [DIST_W-1:0]  ahead;
      logic [DIST_W-1:0]  left_diag;
      logic [DIST_W-1:0]  right_diag;
      logic [DIST_W-1:0]  behind;
   } nav_in_t;

   typedef struct packed {
      logic [3:0]           motor;
      logic [1:0]           servo;
      logic [1:0]           led;
      logic [3:0]           mode;
      logic [BEARING_W-1:0] heading;
   } nav_out_t;

   typedef struct packed {
      nav_in_t  item;
      logic     typed;
      nav_out_t want;
   } nav_row_t;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [47:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tready = 1'b0;
   logic        csr_valid  = 1'b0;
   logic [2:0]  csr_index  = '0;
   logic [15:0] csr_data   = '0;
   wire logic        req_tready;
   wire logic        rsp_tvalid;
   wire logic [23:0] rsp_tdata;
   wire logic        csr_ready;

   obstacle_avoid_nav_fsm_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #CLK_HALF clock = ~clock;

   // Shadow copy of the navigation state and thresholds, at reset values.
   nav_mode_e            mode_q     = MODE_IDLE;
   logic [BEARING_W-1:0] dest_q     = '0;
   logic [15:0]          ticks_left = '0;
   logic [DIST_W-1:0]    stop_cm    = 9'd20;
   logic [DIST_W-1:0]    danger_cm  = 9'd40;
   logic [DIST_W-1:0]    rear_cm    = 9'd15;
   logic [15:0]          pause_len  = 16'd2000;
   logic [15:0]          back_len   = 16'd1500;
   logic [15:0]          settle_len = 16'd1000;
   logic [DEV_W-1:0]     swing_deg  = 8'd40;

   nav_out_t    pending_cmds[$];
   nav_row_t    nav_rows[$];
   logic [15:0] csr_plan[8];
   logic        use_typed  = 1'b0;
   nav_out_t    typed_want = '0;
   int          bad_cnt    = 0;
   int unsigned cycle_cnt  = 0;
   int          rx_cnt     = 0;
   int          rx_style   = 0;
   int          burst_left = 0;
   int          reload_at  = 0;

   task automatic step_nav_model(input nav_in_t it, output nav_out_t o);
      int diff;
      o = '0;
      if (it.action == ACT_START) begin
         mode_q = MODE_STARTING;
         ticks_left = '0;
      end else if (it.action != ACT_TICK) begin
         o.motor = MOT_IDLE;
         o.servo = SERVO_CENTER;
         o.led = LED_OFF;
         mode_q = MODE_IDLE;
         ticks_left = '0;
      end else begin
         case (mode_q)
            MODE_CORRECT: begin
               // Fold the heading error into -180..180 with a single step of 360.
               diff = int'(it.bearing) - int'(dest_q);
               if (diff > int'(DEG_HALF)) diff -= int'(DEG_FULL);
               else if (diff < -int'(DEG_HALF)) diff += int'(DEG_FULL);
               o.motor = (diff > 0) ? MOT_FWD_LEFT : MOT_FWD_RIGHT;
               mode_q = MODE_EXPLORING;
            end
            MODE_EXPLORING: begin
               if (it.bearing != dest_q) mode_q = MODE_CORRECT;
               if (it.ahead < stop_cm) mode_q = MODE_AVOID;
               else if (it.ahead < danger_cm) o.motor = MOT_REDUCED;
               else o.motor = MOT_NORMAL;
            end
            MODE_STARTING: begin
               o.servo = SERVO_SWEEP;
               o.led = LED_ON;
               if (it.left_diag != 0 && it.right_diag != 0 && it.ahead != 0) begin
                  dest_q = BEARING_W'(int'(it.bearing) % int'(DEG_FULL));
                  o.motor = MOT_FWD;
                  mode_q = MODE_EXPLORING;
               end
            end
            MODE_TURNING: begin
               if (it.bearing != dest_q) begin
                  o.motor = (it.bearing < dest_q) ? MOT_RIGHT : MOT_LEFT;
               end else begin
                  o.motor = MOT_IDLE;
                  ticks_left = pause_len;
                  mode_q = MODE_TURN_PAUSE;
               end
            end
            MODE_AVOID: begin
               o.motor = MOT_IDLE;
               o.servo = SERVO_CENTER;
               o.led = LED_OFF;
               ticks_left = pause_len;
               mode_q = MODE_AV_PAUSE;
            end
            MODE_TURN_PAUSE, MODE_AV_PAUSE, MODE_AV_REVERSE, MODE_AV_SETTLE: begin
               if (ticks_left != 0) begin
                  ticks_left = ticks_left - 16'd1;
               end else if (mode_q == MODE_TURN_PAUSE) begin
                  o.motor = MOT_FWD;
                  o.servo = SERVO_SWEEP;
                  o.led = LED_ON;
                  mode_q = MODE_EXPLORING;
               end else if (mode_q == MODE_AV_PAUSE && it.behind > rear_cm) begin
                  o.motor = MOT_BACK;
                  o.servo = SERVO_CENTER;
                  o.led = LED_OFF;
                  ticks_left = back_len;
                  mode_q = MODE_AV_REVERSE;
               end else if (mode_q != MODE_AV_SETTLE) begin
                  // Settling stops the motor but leaves the sweep and LEDs running.
                  o.motor = MOT_IDLE;
                  o.servo = SERVO_SWEEP;
                  o.led = LED_ON;
                  ticks_left = settle_len;
                  mode_q = MODE_AV_SETTLE;
               end else begin
                  if (it.left_diag < it.right_diag)
                     dest_q = BEARING_W'((int'(it.bearing) + int'(swing_deg))
                                         % int'(DEG_FULL));
                  else
                     dest_q = BEARING_W'((int'(it.bearing) + 2 * int'(DEG_FULL)
                                          - int'(swing_deg)) % int'(DEG_FULL));
                  mode_q = MODE_TURNING;
               end
            end
            default: mode_q = MODE_IDLE;
         endcase
      end
      o.mode = mode_q;
      o.heading = dest_q;
   endtask

   always @(posedge clock) begin : watch
      nav_out_t got;
      nav_out_t want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_idx_e'(csr_index))
               CSR_FRONT_STOP:   stop_cm = csr_data[DIST_W-1:0];
               CSR_FRONT_DANGER: danger_cm = csr_data[DIST_W-1:0];
               CSR_REAR_CLEAR:   rear_cm = csr_data[DIST_W-1:0];
               CSR_PAUSE:        pause_len = csr_data;
               CSR_REVERSE:      back_len = csr_data;
               CSR_SETTLE:       settle_len = csr_data;
               CSR_TURN_DEV:     swing_deg = csr_data[DEV_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.motor = rsp_tdata[3:0];
            got.servo = rsp_tdata[5:4];
            got.led = rsp_tdata[7:6];
            got.mode = rsp_tdata[11:8];
            got.heading = rsp_tdata[20:12];
            if (pending_cmds.size() == 0) begin
               bad_cnt++;
               if (bad_cnt <= SHOW_LIMIT)
                  $display("%0t: result item with nothing pending: %h", $time, rsp_tdata);
            end else begin
               want = pending_cmds.pop_front();
               if (got.motor !== want.motor || got.servo !== want.servo ||
                   got.led !== want.led || got.mode !== want.mode ||
                   got.heading !== want.heading) begin
                  bad_cnt++;
                  if (bad_cnt <= SHOW_LIMIT)
                     $display("%0t: motor/servo/led/mode/heading expected %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                              $time, want.motor, want.servo, want.led, want.mode,
                              want.heading, got.motor, got.servo, got.led, got.mode,
                              got.heading);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            step_nav_model(req_tdata[44:0] == req_tdata[44:0] ?
                           nav_in_t'({req_tuser, req_tdata[8:0], req_tdata[17:9],
                                      req_tdata[26:18], req_tdata[35:27],
                                      req_tdata[44:36]}) : '0, want);
            pending_cmds.push_back(use_typed ? typed_want : want);
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // The receiver periodically picks a new stall style at random.
   always @(negedge clock) begin
      rx_cnt++;
      if (rx_cnt % 150 == 0) rx_style = $urandom_range(0, 3);
      case (rx_style)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) == 0);
         2: rsp_tready <= (rx_cnt % 3 == 0);
         default: rsp_tready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   function automatic logic [8:0] near(input int c, input int span);
      int v;
      v = c - span;
      v = v + int'($urandom_range(0, 2 * span));
      if (v < 0) v = 0;
      if (v > 511) v = 511;
      return 9'(v);
   endfunction

   // Ticks are steered by the shadow state so that well-formed runs get deep
   // into the avoidance sequence; the rest is noise.
   function automatic nav_in_t pick_item();
      nav_in_t it;
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) it.action = ACT_START;
      else if (r < 5) it.action = ACT_STOP;
      else if (r == 5) it.action = ACT_STOP_ALT;
      else it.action = ACT_TICK;
      it.bearing = 9'($urandom_range(0, 511));
      r = $urandom_range(0, 99);
      if (((mode_q == MODE_EXPLORING || mode_q == MODE_CORRECT) && r < 60) ||
          (mode_q == MODE_TURNING && r < 35))
         it.bearing = dest_q;
      else if (r < 75)
         it.bearing = near(int'(dest_q), 3);
      r = $urandom_range(0, 99);
      if (r < 30) it.ahead = near(int'(stop_cm), 2);
      else if (r < 50) it.ahead = near(int'(danger_cm), 2);
      else if (r < 55) it.ahead = '0;
      else it.ahead = 9'($urandom_range(0, 511));
      it.left_diag = 9'($urandom_range(0, 511));
      it.right_diag = 9'($urandom_range(0, 511));
      r = $urandom_range(0, 99);
      if (r < 15) it.right_diag = it.left_diag;
      else if (r < 18) it.left_diag = '0;
      else if (r < 21) it.right_diag = '0;
      it.behind = ($urandom_range(0, 1) == 0) ? near(int'(rear_cm), 1)
                                              : 9'($urandom_range(0, 511));
      return it;
   endfunction

   function automatic void add_row(input action_e act, input int b, input int f,
                                   input int l, input int r, input int rr);
      nav_row_t row;
      row.item = {act, 9'(b), 9'(f), 9'(l), 9'(r), 9'(rr)};
      row.typed = 1'b0;
      row.want = '0;
      nav_rows.push_back(row);
   endfunction

   function automatic void add_typed(input action_e act, input int b, input int f,
                                     input int l, input int r, input int rr,
                                     input motor_e m, input servo_e s, input led_e ld,
                                     input nav_mode_e md, input int h);
      nav_row_t row;
      row.item = {act, 9'(b), 9'(f), 9'(l), 9'(r), 9'(rr)};
      row.typed = 1'b1;
      row.want = {m, s, ld, md, 9'(h)};
      nav_rows.push_back(row);
   endfunction

   task automatic push_item(input nav_in_t it);
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, it.behind, it.right_diag, it.left_diag, it.ahead, it.bearing};
      req_tuser <= it.action;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic load_csrs();
      for (int i = 0; i < 8; i++) begin
         csr_valid <= 1'b1;
         csr_index <= 3'(i);
         csr_data <= csr_plan[i];
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      int n;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset thresholds apply to the first rows.
      add_typed(ACT_TICK, 100, 300, 300, 300, 300,
                MOT_NONE, SERVO_NONE, LED_NONE, MODE_IDLE, 0);
      add_typed(ACT_STOP, 0, 0, 0, 0, 0,
                MOT_IDLE, SERVO_CENTER, LED_OFF, MODE_IDLE, 0);
      add_typed(ACT_STOP_ALT, 511, 511, 511, 511, 511,
                MOT_IDLE, SERVO_CENTER, LED_OFF, MODE_IDLE, 0);
      add_typed(ACT_START, 0, 0, 0, 0, 0,
                MOT_NONE, SERVO_NONE, LED_NONE, MODE_STARTING, 0);
      add_typed(ACT_TICK, 200, 100, 0, 100, 100,
                MOT_NONE, SERVO_SWEEP, LED_ON, MODE_STARTING, 0);
      add_typed(ACT_TICK, 359, 511, 511, 511, 511,
                MOT_FWD, SERVO_SWEEP, LED_ON, MODE_EXPLORING, 359);
      add_typed(ACT_TICK, 359, 39, 50, 50, 50,
                MOT_REDUCED, SERVO_NONE, LED_NONE, MODE_EXPLORING, 359);
      add_typed(ACT_TICK, 0, 511, 50, 50, 50,
                MOT_NORMAL, SERVO_NONE, LED_NONE, MODE_CORRECT, 359);
      add_typed(ACT_TICK, 0, 511, 50, 50, 50,
                MOT_FWD_LEFT, SERVO_NONE, LED_NONE, MODE_EXPLORING, 359);
      add_typed(ACT_TICK, 10, 19, 50, 50, 50,
                MOT_NONE, SERVO_NONE, LED_NONE, MODE_AVOID, 359);
      add_typed(ACT_TICK, 10, 19, 50, 50, 50,
                MOT_IDLE, SERVO_CENTER, LED_OFF, MODE_AV_PAUSE, 359);
      add_typed(ACT_TICK, 10, 19, 50, 50, 50,
                MOT_NONE, SERVO_NONE, LED_NONE, MODE_AV_PAUSE, 359);
      add_typed(ACT_STOP, 10, 19, 50, 50, 50,
                MOT_IDLE, SERVO_CENTER, LED_OFF, MODE_IDLE, 359);
      // Zero-length waits and the widest turn from here on.
      reload_at = nav_rows.size();
      add_row(ACT_START,  0,   0,   0,  0,  0);
      add_row(ACT_TICK, 511, 100, 100, 100, 100);
      add_row(ACT_TICK, 151,   5,  50,  50,  16);
      add_row(ACT_TICK, 151,   5,  50,  50,  16);
      add_row(ACT_TICK, 151,   5,  50,  50,  16);
      add_row(ACT_TICK, 151,   5,  50,  50,  16);
      add_row(ACT_TICK, 100,   5,  50,  50,  16);
      add_row(ACT_TICK,  10,   5,  50,  50,  16);
      add_row(ACT_TICK, 300,   5,  50,  50,  16);
      add_row(ACT_TICK, 280,   5,  50,  50,  16);
      add_row(ACT_TICK, 280, 511,  50,  50,  16);
      add_row(ACT_TICK, 270, 511,  50,  50,  16);
      add_row(ACT_TICK, 270, 511,  50,  50,  16);
      add_row(ACT_TICK, 280,   0,  50,  50,  16);
      add_row(ACT_TICK, 280,   0,  50,  50,  15);
      add_row(ACT_TICK, 280,   0,  50,  50,  15);
      add_row(ACT_TICK, 200,   0,   1,   2,  15);
      add_row(ACT_STOP, 200,   0,   1,   2,  15);

      foreach (nav_rows[i]) begin
         if (i == reload_at) begin
            drain();
            csr_plan[CSR_FRONT_STOP] = 16'd20;
            csr_plan[CSR_FRONT_DANGER] = 16'd40;
            csr_plan[CSR_REAR_CLEAR] = 16'd15;
            csr_plan[CSR_PAUSE] = 16'd0;
            csr_plan[CSR_REVERSE] = 16'd0;
            csr_plan[CSR_SETTLE] = 16'd0;
            csr_plan[CSR_TURN_DEV] = 16'd180;
            csr_plan[CSR_UNUSED] = 16'd0;
            load_csrs();
         end
         use_typed = nav_rows[i].typed;
         typed_want = nav_rows[i].want;
         push_item(nav_rows[i].item);
      end
      use_typed = 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         drain();
         if (p == 0) begin
            foreach (csr_plan[k]) csr_plan[k] = 16'h0000;
         end else if (p == 1) begin
            foreach (csr_plan[k]) csr_plan[k] = 16'hFFFF;
            csr_plan[CSR_TURN_DEV] = 16'hFFB4;
         end else begin
            csr_plan[CSR_FRONT_STOP] = {7'($urandom), 9'($urandom_range(0, 120))};
            csr_plan[CSR_FRONT_DANGER] = {7'($urandom),
                                          9'(csr_plan[CSR_FRONT_STOP][8:0]
                                             + 9'($urandom_range(0, 200)))};
            csr_plan[CSR_REAR_CLEAR] = {7'($urandom), 9'($urandom_range(0, 60))};
            csr_plan[CSR_PAUSE] = 16'($urandom_range(0, 3));
            csr_plan[CSR_REVERSE] = 16'($urandom_range(0, 3));
            csr_plan[CSR_SETTLE] = 16'($urandom_range(0, ($urandom_range(0, 3) == 0) ? 20 : 3));
            csr_plan[CSR_TURN_DEV] = {8'($urandom), 8'($urandom_range(0, 180))};
            csr_plan[CSR_UNUSED] = 16'($urandom);
         end
         load_csrs();
         n = 0;
         while (n < ITEMS_PER_PHASE) begin
            if (burst_left == 0) begin
               if ($urandom_range(0, 29) == 0) begin
                  drain();
               end else begin
                  req_tvalid <= 1'b0;
                  repeat ($urandom_range(1, 6)) @(negedge clock);
               end
               burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                        : $urandom_range(1, 12);
            end
            push_item(pick_item());
            n++;
            burst_left--;
         end
      end

      drain();
      repeat (10) @(negedge clock);
      if (bad_cnt == 0 && pending_cmds.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
design/obav_pkg.sv
design/obav_heading.sv
design/obstacle_avoid_nav_fsm_core.sv
dv/tb.sv
